// File: hdl/rpn_pkg.sv
// shared types and token / status codes of the rpn stack evaluator
package rpn_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_DIV,
        S_DIV_FIX,
        S_WRITE,
        S_FINISH
    } seq_state_t;

endpackage

// File: hdl/rpn_ram.sv
// generic single write port, single read port ram with registered read
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/rpn_stack_evaluator_core.sv
// rpn stack evaluator: token sequencer, operand stack and shared alu / divider
// push and ignored tokens go decode, finish; add / sub / mul go decode, execute, write, finish
// divide goes decode, operand read, 32 radix-2 divider iterations, sign fix, write, finish
// one token in flight at a time; s_ready is high only while the sequencer is idle
// a result is presented the cycle after the last token finishes and is held until taken
// synchronous active-low reset clears sequencer, depth, status and m_valid; stack ram untouched
module rpn_stack_evaluator_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    // token channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic signed [31:0] s_operand_value,
    input  logic               s_end_of_expression,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic [1:0]         m_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W = rpn_pkg::DATA_W;
    localparam int CNT_W = $clog2(DATA_W);

    // sequencer and control state
    rpn_pkg::seq_state_t state_reg, state_next;
    logic [DW-1:0]       depth_reg, depth_next;
    rpn_pkg::status_t    sticky_reg, sticky_next;
    logic                m_valid_reg, m_valid_next;

    // latched token
    logic [2:0]          func_reg, func_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic                eoe_reg, eoe_next;

    // top of stack copy, so only the left operand needs a ram read
    logic [DATA_W-1:0]   tos_reg, tos_next;
    logic [DATA_W-1:0]   res_reg, res_next;

    // divider working registers
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   quo_reg, quo_next;
    logic [DATA_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;

    // output registers
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    rpn_pkg::status_t    out_status_reg, out_status_next;

    // stack ram ports
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    // helpers
    logic [DW-1:0]       depth_m2;
    logic                s_fire;
    logic                out_free;
    logic                stack_full;
    logic                too_few;
    logic [DATA_W-1:0]   left_op;
    logic [DATA_W-1:0]   right_op;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     rem_diff;

    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign depth_m2   = depth_reg - DW'(2);
    assign stack_full = depth_reg >= DW'(STACK_DEPTH);
    assign too_few    = depth_reg < DW'(2);
    assign left_op    = ram_rd_data;
    assign right_op   = tos_reg;

    // one radix-2 restoring step
    assign rem_shift  = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_diff   = rem_shift - {1'b0, dvs_reg};

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpn_pkg::S_IDLE: begin
                if (s_fire) begin
                    state_next = rpn_pkg::S_DECODE;
                end
            end
            rpn_pkg::S_DECODE: begin
                // error already latched, push, unused code or underflow finish at once
                priority if (sticky_reg != rpn_pkg::ST_OK) begin
                    state_next = rpn_pkg::S_FINISH;
                end else if (func_reg == rpn_pkg::FUNC_PUSH) begin
                    state_next = rpn_pkg::S_FINISH;
                end else if (func_reg > rpn_pkg::FUNC_DIV) begin
                    state_next = rpn_pkg::S_FINISH;
                end else if (too_few) begin
                    state_next = rpn_pkg::S_FINISH;
                end else begin
                    state_next = rpn_pkg::S_EXEC;
                end
            end
            rpn_pkg::S_EXEC: begin
                if (func_reg == rpn_pkg::FUNC_DIV) begin
                    state_next = (right_op == '0) ? rpn_pkg::S_FINISH : rpn_pkg::S_DIV;
                end else begin
                    state_next = rpn_pkg::S_WRITE;
                end
            end
            rpn_pkg::S_DIV: begin
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    state_next = rpn_pkg::S_DIV_FIX;
                end
            end
            rpn_pkg::S_DIV_FIX: begin
                state_next = rpn_pkg::S_WRITE;
            end
            rpn_pkg::S_WRITE: begin
                state_next = rpn_pkg::S_FINISH;
            end
            rpn_pkg::S_FINISH: begin
                // a last token waits here until the output register is free
                if (!eoe_reg || out_free) begin
                    state_next = rpn_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rpn_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        depth_next      = depth_reg;
        sticky_next     = sticky_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        eoe_next        = eoe_reg;
        tos_next        = tos_reg;
        res_next        = res_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dvs_next        = dvs_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = depth_reg[AW-1:0];
        ram_wr_data     = value_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = depth_m2[AW-1:0];

        // result register drains on a taken transaction
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            rpn_pkg::S_IDLE: begin
                if (s_fire) begin
                    func_next  = s_func;
                    value_next = s_operand_value;
                    eoe_next   = s_end_of_expression;
                end
            end
            rpn_pkg::S_DECODE: begin
                priority if (sticky_reg != rpn_pkg::ST_OK) begin
                    // token ignored
                end else if (func_reg == rpn_pkg::FUNC_PUSH) begin
                    if (stack_full) begin
                        sticky_next = rpn_pkg::ST_OVERFLOW;
                    end else begin
                        ram_wr_en  = 1'b1;
                        tos_next   = value_reg;
                        depth_next = depth_reg + DW'(1);
                    end
                end else if (func_reg > rpn_pkg::FUNC_DIV) begin
                    // unused code, token ignored
                end else if (too_few) begin
                    sticky_next = rpn_pkg::ST_UNDERFLOW;
                end else begin
                    // fetch the left operand, the right one is the top copy
                    ram_rd_en = 1'b1;
                end
            end
            rpn_pkg::S_EXEC: begin
                unique case (func_reg)
                    rpn_pkg::FUNC_ADD: res_next = left_op + right_op;
                    rpn_pkg::FUNC_SUB: res_next = left_op - right_op;
                    rpn_pkg::FUNC_MUL: res_next = left_op * right_op;
                    default: begin
                        // divide: work on magnitudes, fix the sign at the end
                        if (right_op == '0) begin
                            sticky_next = rpn_pkg::ST_DIVZERO;
                        end else begin
                            rem_next = '0;
                            quo_next = left_op[DATA_W-1] ? (DATA_W'(0) - left_op) : left_op;
                            dvs_next = right_op[DATA_W-1] ? (DATA_W'(0) - right_op)
                                                          : right_op;
                            neg_next = left_op[DATA_W-1] ^ right_op[DATA_W-1];
                            cnt_next = '0;
                        end
                    end
                endcase
            end
            rpn_pkg::S_DIV: begin
                if (!rem_diff[DATA_W]) begin
                    rem_next = rem_diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            rpn_pkg::S_DIV_FIX: begin
                res_next = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
            end
            rpn_pkg::S_WRITE: begin
                // result replaces the left operand and becomes the new top
                ram_wr_en   = 1'b1;
                ram_wr_addr = depth_m2[AW-1:0];
                ram_wr_data = res_reg;
                tos_next    = res_reg;
                depth_next  = depth_reg - DW'(1);
            end
            rpn_pkg::S_FINISH: begin
                if (eoe_reg && out_free) begin
                    m_valid_next = 1'b1;
                    priority if (sticky_reg != rpn_pkg::ST_OK) begin
                        out_value_next  = '0;
                        out_status_next = sticky_reg;
                    end else if (depth_reg == '0) begin
                        out_value_next  = '0;
                        out_status_next = rpn_pkg::ST_UNDERFLOW;
                    end else begin
                        out_value_next  = tos_reg;
                        out_status_next = rpn_pkg::ST_OK;
                    end
                    // start a fresh expression
                    depth_next  = '0;
                    sticky_next = rpn_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpn_pkg::S_IDLE;
            depth_reg   <= '0;
            sticky_reg  <= rpn_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        value_reg      <= value_next;
        eoe_reg        <= eoe_next;
        tos_reg        <= tos_next;
        res_reg        <= res_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dvs_reg        <= dvs_next;
        cnt_reg        <= cnt_next;
        neg_reg        <= neg_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign s_ready        = (state_reg == rpn_pkg::S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_status       = out_status_reg;

endmodule

// File: hdl/rpn_checker.sv
// port-level assertions for the rpn stack evaluator and their bind
module rpn_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [2:0]         s_func,
    input logic signed [31:0] s_operand_value,
    input logic               s_end_of_expression,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_result_value,
    input logic [1:0]         m_status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_status))
        else $error("result changed while stalled");

    // failed expression reports zero
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != 2'(rpn_pkg::ST_OK)) |-> m_result_value == 32'sd0)
        else $error("nonzero result with error status");

    // one token at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted token");

    // a new result only comes out of token processing
    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

endmodule

bind rpn_stack_evaluator_core rpn_checker u_rpn_checker (.*);
